### hw/rtl/deque_with_value_search_macros.svh
// Assertion macros used by the deque top level.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef DEQUE_WITH_VALUE_SEARCH_MACROS_SVH
`define DEQUE_WITH_VALUE_SEARCH_MACROS_SVH

// Same-cycle implication.
`define DQVS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DQVS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/dqvs_pkg.sv
// Package for the deque with value search: sizes, request/status codes,
// transaction structs and field conversion helpers. No dependencies.
package dqvs_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_CONTAINS   = 3'd4;
    localparam logic [2:0] REQ_REMOVE     = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [4:0]         entry_count;
        logic               is_empty;
    } rsp_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic                  en;
        logic [2:0]            req_type;
        logic [DATA_WIDTH-1:0] val;
        logic [CNT_W-1:0]      count;
        logic                  full;
        logic                  empty;
    } cell_ctl_t;

    function automatic logic [DATA_WIDTH-1:0] from_field(logic signed [31:0] f);
        logic [63:0] w;
        w = 64'(unsigned'(f));
        return w[DATA_WIDTH-1:0];
    endfunction

    function automatic logic signed [31:0] to_field(logic [DATA_WIDTH-1:0] d);
        logic [63:0] w;
        w = 64'(d);
        return signed'(w[31:0]);
    endfunction

endpackage

### hw/rtl/deque_with_value_search.sv
// Top level of the bounded deque with value search: request/response
// handshake, occupancy count and the row of dqvs_cell. Depends on dqvs_pkg.
//
//  channel | payload | handshake            | direction
//  req     | req_t   | req_valid/req_stall  | in
//  rsp     | rsp_t   | rsp_valid/rsp_stall  | out
//
// The cell row compares and shifts in the cycle a request is taken, the
// response is built from the updated row the next; no new request is taken
// meanwhile. The first-match chain through the cells sets the accept-cycle path.
// Reset clears the count and handshake state only; the cells hold no reset.
// A stalled response holds req_stall high until it is taken.
module deque_with_value_search (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  dqvs_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output dqvs_pkg::rsp_t rsp
);

    `include "deque_with_value_search_macros.svh"

    localparam int N = dqvs_pkg::CAPACITY;
    localparam int DW = dqvs_pkg::DATA_WIDTH;
    localparam int CW = dqvs_pkg::CNT_W;

    logic [CW-1:0]  count_reg, count_next;
    logic           pend_reg;
    logic           rsp_valid_reg;
    logic [1:0]     status_reg, status_next;
    logic           found_reg;
    dqvs_pkg::rsp_t rsp_reg;

    dqvs_pkg::cell_ctl_t ctl;
    logic           req_accept;
    logic           found;

    logic [DW-1:0]  cell_value [N];
    logic [DW-1:0]  left_value [N];
    logic [DW-1:0]  right_value [N];
    logic [DW-1:0]  back_chain [N+1];
    logic           hit_chain [N+1];

    assign req_stall  = pend_reg | (rsp_valid_reg & rsp_stall);
    assign req_accept = req_valid & ~req_stall;

    assign ctl.en       = req_accept;
    assign ctl.req_type = req.req_type;
    assign ctl.val      = dqvs_pkg::from_field(req.item_value);
    assign ctl.count    = count_reg;
    assign ctl.full     = count_reg >= CW'(N);
    assign ctl.empty    = count_reg == '0;

    assign hit_chain[0]  = 1'b0;
    assign back_chain[0] = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_value[i] = ctl.val;
        end
        else
        begin : g_mid
            assign left_value[i] = cell_value[i-1];
        end
        if (i == N - 1)
        begin : g_last
            assign right_value[i] = cell_value[i];
        end
        else
        begin : g_inner
            assign right_value[i] = cell_value[i+1];
        end

        dqvs_cell u_cell (
            .clk         (clk),
            .idx         (dqvs_pkg::IDX_W'(i)),
            .ctl         (ctl),
            .left_value  (left_value[i]),
            .right_value (right_value[i]),
            .hit_in      (hit_chain[i]),
            .back_in     (back_chain[i]),
            .value       (cell_value[i]),
            .hit_out     (hit_chain[i+1]),
            .back_out    (back_chain[i+1])
        );
    end

    assign found = hit_chain[N];

    always_comb
    begin
        count_next  = count_reg;
        status_next = dqvs_pkg::ST_DONE;
        unique case (req.req_type) inside
            dqvs_pkg::REQ_PUSH_FRONT, dqvs_pkg::REQ_PUSH_BACK:
                if (ctl.full) status_next = dqvs_pkg::ST_FULL;
                else          count_next  = count_reg + CW'(1);
            dqvs_pkg::REQ_POP_FRONT, dqvs_pkg::REQ_POP_BACK:
                if (ctl.empty) status_next = dqvs_pkg::ST_EMPTY;
                else           count_next  = count_reg - CW'(1);
            dqvs_pkg::REQ_REMOVE:
                if (ctl.empty)  status_next = dqvs_pkg::ST_EMPTY;
                else if (found) count_next  = count_reg - CW'(1);
            default:
                count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= req_accept;
            if (req_accept)
                count_reg <= count_next;
            if (pend_reg)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            status_reg <= status_next;
            found_reg  <= found && (req.req_type == dqvs_pkg::REQ_CONTAINS
                                    || req.req_type == dqvs_pkg::REQ_REMOVE);
        end
        if (pend_reg)
        begin
            rsp_reg.status      <= status_reg;
            rsp_reg.found       <= found_reg;
            rsp_reg.front_value <= (count_reg != '0) ? dqvs_pkg::to_field(cell_value[0])
                                                     : '0;
            rsp_reg.back_value  <= dqvs_pkg::to_field(back_chain[N]);
            rsp_reg.entry_count <= 5'(count_reg);
            rsp_reg.is_empty    <= count_reg == '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `DQVS_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CW'(N), "count above capacity")
    `DQVS_ASSERT_NEXT(a_accept_pend, req_accept, pend_reg, "accepted request not pending")
    `DQVS_ASSERT_NEXT(a_pend_rsp, pend_reg, rsp_valid_reg, "pending request gave no response")
    `DQVS_ASSERT_IMPL(a_empty_flag, rsp_valid_reg && !pend_reg,
                      rsp_reg.is_empty == (count_reg == '0), "empty flag disagrees with count")

endmodule

### hw/rtl/dqvs_cell.sv
// One storage cell of the deque row: holds a value, compares it against the
// search value and shifts toward either neighbor. Depends on dqvs_pkg.
module dqvs_cell (
    input  logic                           clk,
    input  logic [dqvs_pkg::IDX_W-1:0]     idx,
    input  dqvs_pkg::cell_ctl_t            ctl,
    input  logic [dqvs_pkg::DATA_WIDTH-1:0] left_value,
    input  logic [dqvs_pkg::DATA_WIDTH-1:0] right_value,
    input  logic                           hit_in,
    input  logic [dqvs_pkg::DATA_WIDTH-1:0] back_in,
    output logic [dqvs_pkg::DATA_WIDTH-1:0] value,
    output logic                           hit_out,
    output logic [dqvs_pkg::DATA_WIDTH-1:0] back_out
);

    logic [dqvs_pkg::DATA_WIDTH-1:0] value_reg;
    logic [dqvs_pkg::DATA_WIDTH-1:0] value_next;
    logic [dqvs_pkg::CNT_W-1:0]      pos;
    logic                            occupied;
    logic                            is_last;

    assign pos      = dqvs_pkg::CNT_W'(idx);
    assign occupied = pos < ctl.count;
    assign is_last  = (pos + dqvs_pkg::CNT_W'(1)) == ctl.count;

    // hit_out is set at and behind the first match from the front
    assign hit_out  = hit_in | (occupied && (value_reg == ctl.val));
    assign back_out = back_in | (is_last ? value_reg : '0);
    assign value    = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.en)
        begin
            unique case (ctl.req_type)
                dqvs_pkg::REQ_PUSH_FRONT:
                    if (!ctl.full) value_next = left_value;
                dqvs_pkg::REQ_PUSH_BACK:
                    if (!ctl.full && pos == ctl.count) value_next = ctl.val;
                dqvs_pkg::REQ_POP_FRONT:
                    if (!ctl.empty) value_next = right_value;
                dqvs_pkg::REQ_REMOVE:
                    if (hit_out) value_next = right_value;
                default:
                    value_next = value_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule
